FILE: rtl/ami_pkg.sv
// Package for the affine matrix inverse block: payload types, constants, helpers.
package ami_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   typedef struct packed {
      logic signed [31:0] col0_row0;
      logic signed [31:0] col0_row1;
      logic signed [31:0] col0_row2;
      logic signed [31:0] col1_row0;
      logic signed [31:0] col1_row1;
      logic signed [31:0] col1_row2;
      logic signed [31:0] col2_row0;
      logic signed [31:0] col2_row1;
      logic signed [31:0] col2_row2;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
   } req_type;

   typedef struct packed {
      logic [1:0]         column_index;
      logic signed [31:0] value_0;
      logic signed [31:0] value_1;
      logic signed [31:0] value_2;
      logic signed [31:0] value_3;
      logic               singular;
      logic               last;
   } rsp_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
      logic signed [95:0] hi;
      logic signed [95:0] lo;
      hi = 96'sd2147483647;
      lo = -96'sd2147483648;
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

FILE: rtl/ami_divider.sv
// Pipelined restoring divider: one quotient bit per stage, rounds half away from zero.
module ami_divider #(
   parameter int NUM_W = 80,
   parameter int DEN_W = 66
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [NUM_W-1:0]        in_num,
   input  logic [DEN_W-1:0]        in_den,
   input  logic                    in_neg,
   output logic                    out_valid,
   output logic signed [31:0]      out_quo
);
   import ami_pkg::*;

   localparam int RW = DEN_W + 1;

   logic               v_ff   [NUM_W+1];
   logic [NUM_W-1:0]   n_ff   [NUM_W+1];
   logic [NUM_W-1:0]   q_ff   [NUM_W+1];
   logic [RW-1:0]      r_ff   [NUM_W+1];
   logic [DEN_W-1:0]   d_ff   [NUM_W+1];
   logic               s_ff   [NUM_W+1];
   logic               ov_ff;
   logic signed [31:0] oq_ff;

   // Stage 0 holds the magnitude plus half the divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      n_ff[0] <= in_num + NUM_W'(in_den >> 1);
      q_ff[0] <= '0;
      r_ff[0] <= '0;
      d_ff[0] <= in_den;
      s_ff[0] <= in_neg;
   end

   for (genvar i = 0; i < NUM_W; i++) begin : g_step
      logic [RW:0] trial;
      assign trial = {r_ff[i], n_ff[i][NUM_W-1-i]} - {2'b00, d_ff[i]};
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
         n_ff[i+1] <= n_ff[i];
         d_ff[i+1] <= d_ff[i];
         s_ff[i+1] <= s_ff[i];
         if (!trial[RW]) begin
            r_ff[i+1] <= trial[RW-1:0];
            q_ff[i+1] <= {q_ff[i][NUM_W-2:0], 1'b1};
         end else begin
            r_ff[i+1] <= {r_ff[i][RW-2:0], n_ff[i][NUM_W-1-i]};
            q_ff[i+1] <= {q_ff[i][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= v_ff[NUM_W];
      end
      if (s_ff[NUM_W]) begin
         oq_ff <= sat32(-$signed({16'd0, q_ff[NUM_W]}));
      end else begin
         oq_ff <= sat32($signed({16'd0, q_ff[NUM_W]}));
      end
   end

   assign out_valid = ov_ff;
   assign out_quo   = oq_ff;
endmodule

FILE: rtl/affine_matrix_inverse.sv
// Top level of the affine 4x4 matrix inverse pipeline.
//
// Usage: drive req_payload and pulse start while busy is low; the matrix is
// taken on that edge. Each accepted transaction yields either one singular
// result or four column results (column 0..3, last on column 3), each shown
// on rsp_payload for one cycle with rsp_valid high. The receiver cannot stall.
// busy holds off the next matrix so that the four result slots of one
// transaction never overlap the next; the output sequencer drains one column
// a cycle. From the accepting edge, a matrix passes through capture, cofactor
// products, minors, determinant products and threshold test, then the 80-stage
// bit-serial division pipeline (one quotient bit per stage, nine dividers
// working in parallel, plus an entry and an output register), then translation
// products, translation sum, the sequencer and the response register, which puts
// the first result (column 0 or the singular flag) on the ports.
// csr_write_enable/csr_write_data load the singular threshold at any edge;
// write it only while idle. Reset clears all valid bits and the threshold.
module affine_matrix_inverse #(
   parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ami_pkg::req_type req_payload,
   input  logic            csr_write_enable,
   input  logic [30:0]     csr_write_data,
   output logic            rsp_valid,
   output ami_pkg::rsp_type rsp_payload
);
   import ami_pkg::*;

   localparam int NUM_W = 64 + FRAC_BITS;
   localparam int LAT   = NUM_W + 2;

   logic [30:0]        thr_ff;
   logic [1:0]         gap_ff, gap_in;
   logic               acc;
   logic signed [31:0] m_ff [12];
   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [63:0] p_ff [18];
   logic signed [31:0] mp_ff [12];
   logic signed [31:0] adj_ff [9];
   logic signed [31:0] m2_ff [12];
   logic signed [63:0] dp_ff [3];
   logic signed [31:0] adj3_ff [9];
   logic signed [31:0] m3_ff [3];
   logic signed [65:0] det_ff;
   logic               sing_ff;
   logic signed [31:0] t_ff [3][LAT];
   logic               dsing_ff [LAT];
   logic               dv [9];
   logic signed [31:0] inv [9];
   logic signed [31:0] inv_ff [9];
   logic               tv_ff, ts_ff;
   logic signed [63:0] tp_ff [9];
   logic signed [31:0] inv2_ff [9];
   logic signed [31:0] tr_ff [3];
   logic               rv_ff, rs_ff;
   logic signed [31:0] col_ff [4][3];
   logic [1:0]         oc_ff;
   logic               oa_ff, os_ff;
   rsp_type            rsp_ff, rsp_in;

   // Hold off a new transaction until the previous one's four result slots pass.
   assign acc    = start && !busy;
   assign busy   = gap_ff != 2'd0;
   assign gap_in = acc ? 2'd3 : (gap_ff != 2'd0 ? gap_ff - 2'd1 : 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
         gap_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
         gap_ff <= gap_in;
         v1_ff  <= acc;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
      end
   end

   // Stage 1: capture the matrix.
   always_ff @(posedge clock) begin
      m_ff[0]  <= req_payload.col0_row0;
      m_ff[1]  <= req_payload.col0_row1;
      m_ff[2]  <= req_payload.col0_row2;
      m_ff[3]  <= req_payload.col1_row0;
      m_ff[4]  <= req_payload.col1_row1;
      m_ff[5]  <= req_payload.col1_row2;
      m_ff[6]  <= req_payload.col2_row0;
      m_ff[7]  <= req_payload.col2_row1;
      m_ff[8]  <= req_payload.col2_row2;
      m_ff[9]  <= req_payload.trans_x;
      m_ff[10] <= req_payload.trans_y;
      m_ff[11] <= req_payload.trans_z;
   end

   // Stage 2: eighteen 32x32 products for the nine minors (index = 3*col+row).
   localparam int MA [18] = '{4,8, 7,2, 1,5, 6,5, 0,8, 3,2, 3,7, 6,1, 0,4};
   localparam int MB [18] = '{7,5, 1,8, 4,2, 3,8, 6,2, 0,5, 6,4, 0,7, 3,1};
   for (genvar k = 0; k < 9; k++) begin : g_minor
      always_ff @(posedge clock) begin
         p_ff[2*k]   <= m_ff[MA[2*k]] * m_ff[MA[2*k+1]];
         p_ff[2*k+1] <= m_ff[MB[2*k]] * m_ff[MB[2*k+1]];
      end
   end
   always_ff @(posedge clock) begin
      mp_ff <= m_ff;
   end

   // Stage 3: floor and saturate the minors; matrix advances beside them.
   for (genvar k = 0; k < 9; k++) begin : g_adj
      logic signed [64:0] diff;
      assign diff = 65'(p_ff[2*k]) - 65'(p_ff[2*k+1]);
      always_ff @(posedge clock) begin
         adj_ff[k] <= sat32(96'(diff >>> FRAC_BITS));
      end
   end
   always_ff @(posedge clock) begin
      m2_ff <= mp_ff;
   end

   // Stage 4: determinant products down column 0.
   always_ff @(posedge clock) begin
      dp_ff[0] <= m2_ff[0] * adj_ff[0];
      dp_ff[1] <= m2_ff[1] * adj_ff[3];
      dp_ff[2] <= m2_ff[2] * adj_ff[6];
      adj3_ff  <= adj_ff;
      m3_ff[0] <= m2_ff[9];
      m3_ff[1] <= m2_ff[10];
      m3_ff[2] <= m2_ff[11];
   end

   // Stage 5: sum, floor, threshold test.
   logic signed [65:0] dsum, dabs;
   assign dsum = (66'(dp_ff[0]) + 66'(dp_ff[1]) + 66'(dp_ff[2])) >>> FRAC_BITS;
   assign dabs = dsum[65] ? -dsum : dsum;
   logic signed [31:0] adj4_ff [9];
   logic signed [31:0] t4_ff [3];
   always_ff @(posedge clock) begin
      det_ff  <= dsum;
      sing_ff <= dabs <= $signed({35'd0, thr_ff});
      adj4_ff <= adj3_ff;
      t4_ff   <= m3_ff;
   end

   // Stage 6 onward: nine dividers; translation and flag ride alongside.
   logic [65:0] aden;
   assign aden = det_ff[65] ? 66'(-det_ff) : 66'(det_ff);
   for (genvar k = 0; k < 9; k++) begin : g_div
      logic [NUM_W-1:0] an;
      logic signed [NUM_W-1:0] sn;
      assign sn = NUM_W'(adj4_ff[k]) <<< FRAC_BITS;
      assign an = adj4_ff[k][31] ? NUM_W'(-sn) : NUM_W'(sn);
      ami_divider #(.NUM_W(NUM_W), .DEN_W(66)) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v5_ff),
         .in_num    (an),
         .in_den    (aden | 66'(det_ff == 66'sd0)),
         .in_neg    (adj4_ff[k][31] ^ det_ff[65]),
         .out_valid (dv[k]),
         .out_quo   (inv[k])
      );
   end

   always_ff @(posedge clock) begin
      t_ff[0][0]  <= t4_ff[0];
      t_ff[1][0]  <= t4_ff[1];
      t_ff[2][0]  <= t4_ff[2];
      dsing_ff[0] <= sing_ff;
      for (int i = 1; i < LAT; i++) begin
         t_ff[0][i]  <= t_ff[0][i-1];
         t_ff[1][i]  <= t_ff[1][i-1];
         t_ff[2][i]  <= t_ff[2][i-1];
         dsing_ff[i] <= dsing_ff[i-1];
      end
   end

   // Translation: products, then sum and floor of the negation.
   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         tv_ff <= dv[0];
         rv_ff <= tv_ff;
      end
      for (int r = 0; r < 3; r++) begin
         tp_ff[r]   <= t_ff[0][LAT-1] * inv[r];
         tp_ff[3+r] <= t_ff[1][LAT-1] * inv[3+r];
         tp_ff[6+r] <= t_ff[2][LAT-1] * inv[6+r];
      end
      inv2_ff <= inv;
      ts_ff   <= dsing_ff[LAT-1];
      inv_ff  <= inv2_ff;
      rs_ff   <= ts_ff;
      for (int r = 0; r < 3; r++) begin
         tr_ff[r] <= sat32(96'((-(67'(tp_ff[r]) + 67'(tp_ff[3+r]) + 67'(tp_ff[6+r])))
                               >>> FRAC_BITS));
      end
   end

   // Output sequencer: load four columns, shift out one per cycle; a singular
   // transaction takes only the first slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         oa_ff <= 1'b0;
         oc_ff <= '0;
      end else if (rv_ff) begin
         oa_ff <= 1'b1;
         oc_ff <= 2'd0;
      end else if (oa_ff) begin
         oc_ff <= oc_ff + 2'd1;
         oa_ff <= !os_ff && oc_ff != 2'd3;
      end
      if (rv_ff) begin
         os_ff <= rs_ff;
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               col_ff[c][r] <= inv_ff[3*c+r];
            end
         end
         col_ff[3] <= tr_ff;
      end
   end

   logic sv_ff;
   always_comb begin
      rsp_in              = '0;
      rsp_in.column_index = oc_ff;
      if (oa_ff && !os_ff) begin
         rsp_in.value_0 = col_ff[oc_ff][0];
         rsp_in.value_1 = col_ff[oc_ff][1];
         rsp_in.value_2 = col_ff[oc_ff][2];
         rsp_in.value_3 = (oc_ff == 2'd3) ? 32'(1 << FRAC_BITS) : 32'sd0;
         rsp_in.last    = oc_ff == 2'd3;
      end else begin
         rsp_in.column_index = 2'd0;
         rsp_in.singular     = 1'b1;
         rsp_in.last         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else begin
         sv_ff <= oa_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = sv_ff;
   assign rsp_payload = rsp_ff;

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      acc |=> busy) else $error("busy not raised after accept");
   a_last_col3: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.singular |->
         rsp_payload.last == (rsp_payload.column_index == 2'd3))
      else $error("last misplaced");
   a_sing_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.singular |-> rsp_payload.last) else $error("singular not last");
endmodule

FILE: test/tb_top.sv
// Testbench for affine_matrix_inverse: directed and random matrices checked against a local predictor.
`timescale 1ns / 1ps

module tb_top;
   import ami_pkg::*;

   localparam int FRAC = 16;
   localparam int DRAIN_CYCLES = 120;
   localparam logic signed [31:0] FX_ONE = 32'sh0001_0000;
   localparam logic signed [31:0] FX_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;
   localparam logic [30:0] THRESH_MAX = 31'h7fff_ffff;

   typedef logic signed [127:0] wide_t;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    csr_write_enable;
   logic [30:0] csr_write_data;
   logic    rsp_valid;
   rsp_type rsp_payload;

   // Testbench copy of the singular threshold register.
   logic [30:0] threshold_shadow;
   // Column results still owed by the block, oldest first.
   rsp_type pending_columns[$];
   int mismatch_count;
   bit quiet_sender;  // no sender gaps in the last part of the run

   affine_matrix_inverse i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: fixed-point inverse of the affine matrix
   // ---------------------------------------------------------------------

   // Clamp to the signed 32-bit range.
   function automatic logic signed [31:0] clamp32(input wide_t v);
      if (v > wide_t'(FX_MAX)) return FX_MAX;
      if (v < wide_t'(FX_MIN)) return FX_MIN;
      return v[31:0];
   endfunction

   // 2x2 minor a*b - c*d, floored to Q16.16 and clamped.
   function automatic logic signed [31:0] minor_fx(input wide_t a, input wide_t b,
                                                   input wide_t c, input wide_t d);
      wide_t diff;
      diff = a * b - c * d;
      return clamp32(diff >>> FRAC);
   endfunction

   // cofactor * 2^F / det, rounded half away from zero, clamped.
   function automatic logic signed [31:0] recip_scale(input wide_t cof, input wide_t det);
      wide_t num;
      logic [127:0] num_mag;
      logic [127:0] det_mag;
      logic [127:0] q;
      num = cof * wide_t'(FX_ONE);
      num_mag = (num < 0) ? -num : num;
      det_mag = (det < 0) ? -det : det;
      q = (num_mag + det_mag / 2) / det_mag;
      if ((num < 0) != (det < 0)) return clamp32(-$signed(q));
      return clamp32($signed(q));
   endfunction

   // Work out the results of one accepted matrix and queue them.
   task automatic predict_inverse(input req_type m);
      wide_t lin[3][3];   // [column][row]
      wide_t tv[3];
      wide_t adj[3][3];
      logic signed [31:0] inv[3][3];
      logic signed [31:0] tr[3];
      wide_t det;
      logic [127:0] det_mag;
      rsp_type col;
      lin[0][0] = $signed(m.col0_row0); lin[0][1] = $signed(m.col0_row1);
      lin[0][2] = $signed(m.col0_row2);
      lin[1][0] = $signed(m.col1_row0); lin[1][1] = $signed(m.col1_row1);
      lin[1][2] = $signed(m.col1_row2);
      lin[2][0] = $signed(m.col2_row0); lin[2][1] = $signed(m.col2_row1);
      lin[2][2] = $signed(m.col2_row2);
      tv[0] = $signed(m.trans_x); tv[1] = $signed(m.trans_y); tv[2] = $signed(m.trans_z);

      adj[0][0] = minor_fx(lin[1][1], lin[2][2], lin[2][1], lin[1][2]);
      adj[0][1] = minor_fx(lin[2][1], lin[0][2], lin[0][1], lin[2][2]);
      adj[0][2] = minor_fx(lin[0][1], lin[1][2], lin[1][1], lin[0][2]);
      adj[1][0] = minor_fx(lin[2][0], lin[1][2], lin[1][0], lin[2][2]);
      adj[1][1] = minor_fx(lin[0][0], lin[2][2], lin[2][0], lin[0][2]);
      adj[1][2] = minor_fx(lin[1][0], lin[0][2], lin[0][0], lin[1][2]);
      adj[2][0] = minor_fx(lin[1][0], lin[2][1], lin[2][0], lin[1][1]);
      adj[2][1] = minor_fx(lin[2][0], lin[0][1], lin[0][0], lin[2][1]);
      adj[2][2] = minor_fx(lin[0][0], lin[1][1], lin[1][0], lin[0][1]);

      // Determinant stays at full width for the threshold test and division.
      det = (lin[0][0] * adj[0][0] + lin[0][1] * adj[1][0] + lin[0][2] * adj[2][0]) >>> FRAC;
      det_mag = (det < 0) ? -det : det;

      if (det_mag <= {97'd0, threshold_shadow}) begin
         col = '0;
         col.singular = 1'b1;
         col.last = 1'b1;
         pending_columns.push_back(col);
         return;
      end

      for (int c = 0; c < 3; c++)
         for (int r = 0; r < 3; r++)
            inv[c][r] = recip_scale(adj[c][r], det);

      // New translation uses the clamped inverse entries.
      for (int r = 0; r < 3; r++)
         tr[r] = clamp32((-(tv[0] * inv[0][r]) - tv[1] * inv[1][r] - tv[2] * inv[2][r])
                         >>> FRAC);

      for (int c = 0; c < 4; c++) begin
         col = '0;
         col.column_index = c[1:0];
         col.value_0 = (c < 3) ? inv[c][0] : tr[0];
         col.value_1 = (c < 3) ? inv[c][1] : tr[1];
         col.value_2 = (c < 3) ? inv[c][2] : tr[2];
         col.value_3 = (c == 3) ? FX_ONE : '0;
         col.last = (c == 3);
         pending_columns.push_back(col);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checker: the block cannot be stalled, so sample every strobe.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_columns.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result %p", $realtime, rsp_payload);
         end else begin
            want = pending_columns.pop_front();
            if (rsp_payload.column_index !== want.column_index ||
                rsp_payload.value_0 !== want.value_0 ||
                rsp_payload.value_1 !== want.value_1 ||
                rsp_payload.value_2 !== want.value_2 ||
                rsp_payload.value_3 !== want.value_3 ||
                rsp_payload.singular !== want.singular ||
                rsp_payload.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch expected %p actual %p", $realtime, want,
                           rsp_payload);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Present one matrix and hold it until the block takes it. Start is left
   // high so back-to-back transactions never drop it within one time step.
   task automatic send_matrix(input req_type m);
      @(negedge clock);
      start <= 1'b1;
      req_payload <= m;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predict_inverse(m);
   endtask

   // Drop start for a random burst now and then.
   task automatic sender_gap();
      int n;
      if (quiet_sender || $urandom_range(0, 3) != 0) return;
      n = $urandom_range(1, 17);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Wait for every owed result, then let the pipeline settle.
   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      while (pending_columns.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Load the threshold; only called with the block idle.
   task automatic write_threshold(input logic [30:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      threshold_shadow = value;
   endtask

   function automatic req_type diag_matrix(input logic signed [31:0] d0,
                                           input logic signed [31:0] d1,
                                           input logic signed [31:0] d2,
                                           input logic signed [31:0] tx,
                                           input logic signed [31:0] ty,
                                           input logic signed [31:0] tz);
      req_type m;
      m = '0;
      m.col0_row0 = d0; m.col1_row1 = d1; m.col2_row2 = d2;
      m.trans_x = tx; m.trans_y = ty; m.trans_z = tz;
      return m;
   endfunction

   // Entry drawn from one of several value classes.
   function automatic logic signed [31:0] random_entry(input int mode);
      case (mode)
         0: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         1: return FX_ONE * ($signed($urandom_range(0, 2)) - 1);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_matrix();
      req_type m;
      int mode;
      int pick;
      pick = $urandom_range(0, 9);
      mode = (pick < 6) ? 0 : (pick < 8) ? 1 : 2;
      m.col0_row0 = random_entry(mode); m.col0_row1 = random_entry(mode);
      m.col0_row2 = random_entry(mode); m.col1_row0 = random_entry(mode);
      m.col1_row1 = random_entry(mode); m.col1_row2 = random_entry(mode);
      m.col2_row0 = random_entry(mode); m.col2_row1 = random_entry(mode);
      m.col2_row2 = random_entry(mode);
      // Translations range widely even on well-scaled matrices.
      m.trans_x = ($urandom_range(0, 1) != 0) ? $urandom : random_entry(0);
      m.trans_y = ($urandom_range(0, 1) != 0) ? $urandom : random_entry(0);
      m.trans_z = ($urandom_range(0, 1) != 0) ? $urandom : random_entry(0);
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Identity, scaling, a signed permutation with positive determinant, then a random matrix.
   task automatic test_regular_matrices();
      req_type m;
      send_matrix(diag_matrix(FX_ONE, FX_ONE, FX_ONE, 32'sh0003_0000, -32'sh0001_8000,
                              32'sh0000_4000));
      send_matrix(diag_matrix(32'sh0002_0000, 32'sh0000_8000, 32'sh0004_0000,
                              -32'sh0005_0000, 32'sh0001_0000, -32'sh0000_0001));
      m = '0;
      m.col0_row1 = FX_ONE; m.col1_row0 = FX_ONE; m.col2_row2 = -FX_ONE;
      m.trans_x = 32'sh0007_0000; m.trans_y = -32'sh0002_0000;
      send_matrix(m);
      m = random_matrix();
      m.col0_row0 = 32'sh0001_8000; m.col1_row1 = -32'sh0002_4000;
      send_matrix(m);
   endtask

   // Zero determinant, clamped inverse entries and clamped translation.
   task automatic test_singular_and_clamping();
      send_matrix('0);
      send_matrix(diag_matrix(FX_ONE, FX_ONE, 32'sh0000_0001, 0, 0, 0));
      send_matrix(diag_matrix(32'sh0000_0002, FX_ONE, FX_ONE, FX_ONE, 0, 0));
      send_matrix(diag_matrix(-32'sh0000_0002, FX_ONE, FX_ONE, -FX_ONE, 0, 0));
      send_matrix(diag_matrix(FX_ONE, FX_ONE, FX_ONE, FX_MIN, FX_MAX, FX_MIN));
      send_matrix(diag_matrix(-FX_ONE, FX_ONE, -FX_ONE, FX_MIN, FX_MIN, FX_MAX));
      send_matrix({12{FX_MAX}});
      send_matrix({12{FX_MIN}});
      send_matrix(diag_matrix(FX_MAX, FX_MIN, FX_MAX, FX_MAX, FX_MIN, FX_MAX));
      send_matrix(diag_matrix(FX_MIN, FX_MIN, FX_MIN, FX_MAX, FX_MAX, FX_MAX));
      send_matrix({{6{32'sh5555_5555}}, {6{32'shaaaa_aaaa}}});
      send_matrix({{6{32'shaaaa_aaaa}}, {6{32'sh5555_5555}}});
   endtask

   // Threshold edges: just below and at the determinant, then the maximum threshold.
   task automatic test_threshold_edges();
      // diag(2,2,2) has determinant 8.0 = 0x80000
      drain_block();
      write_threshold(31'h0007_ffff);
      send_matrix(diag_matrix(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, FX_ONE,
                              FX_ONE, FX_ONE));
      drain_block();
      write_threshold(31'h0008_0000);
      send_matrix(diag_matrix(32'sh0002_0000, 32'sh0002_0000, -32'sh0002_0000, FX_ONE,
                              FX_ONE, FX_ONE));
      drain_block();
      write_threshold(THRESH_MAX);
      send_matrix(diag_matrix(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 0, 0, 0));
      send_matrix({12{FX_MAX}});
      send_matrix(diag_matrix(FX_MAX, FX_MAX, FX_MAX, 0, 0, 0));
      drain_block();
      write_threshold('0);
   endtask

   // Random matrices under one threshold setting.
   task automatic test_random_matrices(input int count, input logic [30:0] thresh,
                                       input bit quiet);
      drain_block();
      write_threshold(thresh);
      quiet_sender = quiet;
      repeat (count) begin
         sender_gap();
         send_matrix(random_matrix());
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      threshold_shadow = '0;
      mismatch_count = 0;
      quiet_sender = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_threshold('0);
      test_regular_matrices();
      test_singular_and_clamping();
      test_threshold_edges();
      test_random_matrices(60, '0, 1'b0);
      test_random_matrices(50, 31'h0000_4000, 1'b0);
      test_random_matrices(15, THRESH_MAX, 1'b0);
      test_random_matrices(25, 31'($urandom_range(1, 32'h0010_0000)), 1'b0);
      // Final stretch runs back to back.
      test_random_matrices(50, '0, 1'b1);

      drain_block();
      if (mismatch_count == 0 && pending_columns.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #3ms;
      $display("FAIL");
      $finish;
   end

endmodule
